// ===== sv/rlc_pkg.sv =====
`default_nettype none

package rlc_pkg;

  localparam int TIME_W = 32;
  localparam int SEQ_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] EV_OPEN      = 3'd0;
  localparam logic [2:0] EV_TICK      = 3'd1;
  localparam logic [2:0] EV_PACKET    = 3'd2;
  localparam logic [2:0] EV_DISC_REQ  = 3'd3;
  localparam logic [2:0] EV_NEW_REL   = 3'd4;
  localparam logic [2:0] EV_HS_DONE   = 3'd5;

  localparam logic [2:0] PT_DISC      = 3'd0;
  localparam logic [2:0] PT_DISC_ACK  = 3'd1;
  localparam logic [2:0] PT_KEEPALIVE = 3'd2;
  localparam logic [2:0] PT_REL_ACK   = 3'd3;
  localparam logic [2:0] PT_OTHER     = 3'd4;

  localparam logic [2:0] ST_CONNECTING    = 3'd0;
  localparam logic [2:0] ST_CONNECTED     = 3'd1;
  localparam logic [2:0] ST_DISCONNECTING = 3'd2;
  localparam logic [2:0] ST_SLEEP         = 3'd3;
  localparam logic [2:0] ST_DISCONNECTED  = 3'd4;

  localparam logic [1:0] RS_NONE    = 2'd0;
  localparam logic [1:0] RS_LOCAL   = 2'd1;
  localparam logic [1:0] RS_REMOTE  = 2'd2;
  localparam logic [1:0] RS_TIMEOUT = 2'd3;

  localparam logic [2:0] SK_STATUS    = 3'd0;
  localparam logic [2:0] SK_KEEPALIVE = 3'd1;
  localparam logic [2:0] SK_DISC      = 3'd2;
  localparam logic [2:0] SK_DISC_ACK  = 3'd3;
  localparam logic [2:0] SK_REL_ACK   = 3'd4;
  localparam logic [2:0] SK_RESEND    = 3'd5;
  localparam logic [2:0] SK_NEW_REL   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_IS_SERVER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_MS     = 3'd6;

  localparam logic [TIME_W-1:0] TIMEOUT_MS_RST   = 32'd30000;
  localparam logic [TIME_W-1:0] KEEPALIVE_MS_RST = 32'd1000;
  localparam logic [TIME_W-1:0] RESEND_MS_RST    = 32'd1000;
  localparam logic [TIME_W-1:0] RETRY_MS_RST     = 32'd1000;
  localparam logic [3:0]        RETRY_LIMIT_RST  = 4'd5;
  localparam logic [TIME_W-1:0] SLEEP_MS_RST     = 32'd5000;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TIME_W-1:0] now_ms;
    logic [2:0]        pkt_type;
    logic              reliable_flag;
    logic [SEQ_W-1:0]  header_seq;
    logic              header_seq_present;
    logic [SEQ_W-1:0]  ack_seq;
    logic              ack_seq_present;
  } in_item_t;

  typedef struct packed {
    logic              is_server;
    logic [TIME_W-1:0] timeout_ms;
    logic [TIME_W-1:0] keepalive_ms;
    logic [TIME_W-1:0] resend_ms;
    logic [TIME_W-1:0] retry_ms;
    logic [3:0]        retry_limit;
    logic [TIME_W-1:0] sleep_ms;
  } cfg_t;

  // sends of one request, followed by one status item
  typedef struct packed {
    logic [1:0][2:0]       send_kind;
    logic [1:0][SEQ_W-1:0] send_seq;
    logic [1:0]            n_send;
    logic [2:0]            link_state;
    logic [1:0]            reason;
    logic                  eaten;
    logic                  queue_full;
  } grp_t;

  typedef struct packed {
    logic [2:0]       send_kind;
    logic [SEQ_W-1:0] send_seq;
    logic [2:0]       link_state;
    logic [1:0]       reason;
    logic             eaten;
    logic             queue_full;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/rlc_engine.sv =====
`default_nettype none

module rlc_engine #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire rlc_pkg::in_item_t item,
  input  wire rlc_pkg::cfg_t     cfg,
  output rlc_pkg::grp_t          grp
);

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SW     = rlc_pkg::SEQ_W;
  localparam int TW     = rlc_pkg::TIME_W;

  logic [2:0]        st_r, st_nxt;
  logic [1:0]        rs_r, rs_nxt;
  logic [SW-1:0]     send_seq_r, send_seq_nxt;
  logic [SW-1:0]     recv_seq_r, recv_seq_nxt;
  logic [TW-1:0]     last_recv_r, last_recv_nxt;
  logic [TW-1:0]     last_send_r, last_send_nxt;
  logic [TW-1:0]     disc_time_r, disc_time_nxt;
  logic              disc_vld_r, disc_vld_nxt;
  logic [3:0]        retry_r, retry_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [TW-1:0]     head_time_r, head_time_nxt;
  logic              head_vld_r, head_vld_nxt;

  logic [SW-1:0]     head_seq;
  logic [TW-1:0]     d_recv, d_send, d_head, d_disc;
  logic              pend_nz, pend_full;
  logic              stop, in_order, eaten, full;
  logic [SW-1:0]     ack_val;
  logic [1:0]        n_send;
  logic [1:0][2:0]   s_kind;
  logic [1:0][SW-1:0] s_seq;

  assign head_seq  = send_seq_r - SW'(pend_r);
  assign d_recv    = item.now_ms - last_recv_r;
  assign d_send    = item.now_ms - last_send_r;
  assign d_head    = item.now_ms - head_time_r;
  assign d_disc    = item.now_ms - disc_time_r;
  assign pend_nz   = (pend_r != '0);
  assign pend_full = (pend_r >= PEND_W'(QUEUE_DEPTH));

  always_comb begin
    st_nxt        = st_r;
    rs_nxt        = rs_r;
    send_seq_nxt  = send_seq_r;
    recv_seq_nxt  = recv_seq_r;
    last_recv_nxt = last_recv_r;
    last_send_nxt = last_send_r;
    disc_time_nxt = disc_time_r;
    disc_vld_nxt  = disc_vld_r;
    retry_nxt     = retry_r;
    pend_nxt      = pend_r;
    head_time_nxt = head_time_r;
    head_vld_nxt  = head_vld_r;
    n_send        = 2'd0;
    s_kind        = '0;
    s_seq         = '0;
    eaten         = 1'b0;
    full          = 1'b0;
    stop          = 1'b0;
    in_order      = 1'b0;
    ack_val       = recv_seq_r;

    unique case (item.kind)
      rlc_pkg::EV_OPEN: begin
        disc_vld_nxt  = 1'b0;
        disc_time_nxt = '0;
        retry_nxt     = '0;
        pend_nxt      = '0;
        head_vld_nxt  = 1'b0;
        head_time_nxt = '0;
        send_seq_nxt  = '0;
        recv_seq_nxt  = '0;
        last_recv_nxt = item.now_ms;
        last_send_nxt = item.now_ms;
        rs_nxt        = rlc_pkg::RS_NONE;
        st_nxt        = cfg.is_server ? rlc_pkg::ST_CONNECTED : rlc_pkg::ST_CONNECTING;
      end
      rlc_pkg::EV_TICK: begin
        unique case (st_r)
          rlc_pkg::ST_CONNECTED: begin
            if (d_recv > cfg.timeout_ms) begin
              st_nxt = rlc_pkg::ST_DISCONNECTED;
              rs_nxt = rlc_pkg::RS_TIMEOUT;
            end
            if (d_send > cfg.keepalive_ms) begin
              s_kind[n_send[0]] = rlc_pkg::SK_KEEPALIVE;
              n_send            = n_send + 2'd1;
              last_send_nxt     = item.now_ms;
            end
            if (pend_nz && (!head_vld_r || d_head > cfg.resend_ms)) begin
              s_kind[n_send[0]] = rlc_pkg::SK_RESEND;
              s_seq[n_send[0]]  = head_seq;
              n_send            = n_send + 2'd1;
              last_send_nxt     = item.now_ms;
              head_time_nxt     = item.now_ms;
              head_vld_nxt      = 1'b1;
            end
          end
          rlc_pkg::ST_DISCONNECTING: begin
            if (!disc_vld_r || d_disc > cfg.retry_ms) begin
              if (retry_r < cfg.retry_limit) begin
                s_kind[n_send[0]] = rlc_pkg::SK_DISC;
                n_send            = n_send + 2'd1;
                last_send_nxt     = item.now_ms;
                disc_time_nxt     = item.now_ms;
                disc_vld_nxt      = 1'b1;
                retry_nxt         = retry_r + 4'd1;
              end else begin
                st_nxt = rlc_pkg::ST_DISCONNECTED;
                rs_nxt = rlc_pkg::RS_LOCAL;
              end
            end
          end
          rlc_pkg::ST_SLEEP: begin
            if (d_disc > cfg.sleep_ms) begin
              st_nxt = rlc_pkg::ST_DISCONNECTED;
              rs_nxt = rlc_pkg::RS_REMOTE;
            end
          end
          default: begin
          end
        endcase
      end
      rlc_pkg::EV_PACKET: begin
        last_recv_nxt = item.now_ms;
        eaten         = 1'b1;
        if (item.reliable_flag) begin
          if (!item.header_seq_present) begin
            stop = 1'b1;
          end else begin
            in_order          = (item.header_seq == recv_seq_r);
            ack_val           = in_order ? recv_seq_r + SW'(1) : recv_seq_r;
            recv_seq_nxt      = ack_val;
            s_kind[n_send[0]] = rlc_pkg::SK_REL_ACK;
            s_seq[n_send[0]]  = ack_val;
            n_send            = n_send + 2'd1;
            last_send_nxt     = item.now_ms;
            stop              = !in_order;
          end
        end
        if (!stop) begin
          unique case (item.pkt_type)
            rlc_pkg::PT_DISC: begin
              s_kind[n_send[0]] = rlc_pkg::SK_DISC_ACK;
              n_send            = n_send + 2'd1;
              last_send_nxt     = item.now_ms;
              disc_time_nxt     = item.now_ms;
              disc_vld_nxt      = 1'b1;
              st_nxt            = rlc_pkg::ST_SLEEP;
              rs_nxt            = rlc_pkg::RS_REMOTE;
            end
            rlc_pkg::PT_DISC_ACK: begin
              if (st_r == rlc_pkg::ST_DISCONNECTING) begin
                st_nxt       = rlc_pkg::ST_DISCONNECTED;
                rs_nxt       = rlc_pkg::RS_LOCAL;
                disc_vld_nxt = 1'b0;
              end
            end
            rlc_pkg::PT_KEEPALIVE: begin
            end
            rlc_pkg::PT_REL_ACK: begin
              if (item.ack_seq_present && pend_nz && item.ack_seq == head_seq + SW'(1)) begin
                pend_nxt     = pend_r - PEND_W'(1);
                head_vld_nxt = 1'b0;
              end
            end
            default: begin
              eaten = 1'b0;
            end
          endcase
        end
      end
      rlc_pkg::EV_DISC_REQ: begin
        if (st_r != rlc_pkg::ST_DISCONNECTED && st_r != rlc_pkg::ST_DISCONNECTING &&
            st_r != rlc_pkg::ST_SLEEP) begin
          st_nxt       = rlc_pkg::ST_DISCONNECTING;
          rs_nxt       = rlc_pkg::RS_LOCAL;
          disc_vld_nxt = 1'b0;
          retry_nxt    = '0;
        end
      end
      rlc_pkg::EV_NEW_REL: begin
        if (pend_full) begin
          full = 1'b1;
        end else begin
          s_kind[n_send[0]] = rlc_pkg::SK_NEW_REL;
          s_seq[n_send[0]]  = send_seq_r;
          n_send            = n_send + 2'd1;
          if (!pend_nz) begin
            head_vld_nxt = 1'b0;
          end
          pend_nxt     = pend_r + PEND_W'(1);
          send_seq_nxt = send_seq_r + SW'(1);
        end
      end
      rlc_pkg::EV_HS_DONE: begin
        if (st_r == rlc_pkg::ST_CONNECTING) begin
          st_nxt = rlc_pkg::ST_CONNECTED;
        end
      end
      default: begin
      end
    endcase

    grp.send_kind  = s_kind;
    grp.send_seq   = s_seq;
    grp.n_send     = n_send;
    grp.link_state = st_nxt;
    grp.reason     = rs_nxt;
    grp.eaten      = eaten;
    grp.queue_full = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rlc_pkg::ST_CONNECTING;
      rs_r        <= rlc_pkg::RS_NONE;
      send_seq_r  <= '0;
      recv_seq_r  <= '0;
      last_recv_r <= '0;
      last_send_r <= '0;
      disc_time_r <= '0;
      disc_vld_r  <= 1'b0;
      retry_r     <= '0;
      pend_r      <= '0;
      head_time_r <= '0;
      head_vld_r  <= 1'b0;
    end else if (fire) begin
      st_r        <= st_nxt;
      rs_r        <= rs_nxt;
      send_seq_r  <= send_seq_nxt;
      recv_seq_r  <= recv_seq_nxt;
      last_recv_r <= last_recv_nxt;
      last_send_r <= last_send_nxt;
      disc_time_r <= disc_time_nxt;
      disc_vld_r  <= disc_vld_nxt;
      retry_r     <= retry_nxt;
      pend_r      <= pend_nxt;
      head_time_r <= head_time_nxt;
      head_vld_r  <= head_vld_nxt;
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(QUEUE_DEPTH))
    else $error("pending count beyond queue depth");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pend_r) && $stable(st_r) && $stable(send_seq_r))
    else $error("link state moved without a request");

  a_full_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full |-> n_send == 2'd0 && pend_nxt == pend_r)
    else $error("refused request changed the queue");

endmodule

`default_nettype wire

// ===== sv/rlc_grp_fifo.sv =====
`default_nettype none

module rlc_grp_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rlc_pkg::grp_t  grp_in,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rlc_pkg::res_t       res
);

  rlc_pkg::grp_t mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;
  rlc_pkg::grp_t head;
  logic       take, grp_done;

  assign head      = mem_r[rd_r];
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign take      = out_valid && !out_stall;
  assign grp_done  = take && (idx_r == head.n_send);

  always_comb begin
    res.link_state = head.link_state;
    res.reason     = head.reason;
    res.eaten      = head.eaten;
    res.queue_full = head.queue_full;
    if (idx_r == head.n_send) begin
      res.send_kind = rlc_pkg::SK_STATUS;
      res.send_seq  = '0;
      res.last      = 1'b1;
    end else begin
      res.send_kind = head.send_kind[idx_r[0]];
      res.send_seq  = head.send_seq[idx_r[0]];
      res.last      = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, grp_done})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (grp_done) begin
        rd_r  <= ~rd_r;
        idx_r <= 2'd0;
      end else if (take) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("request group pushed into full buffer");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r <= head.n_send)
    else $error("item index past status item");

  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.last && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("final item did not retire its group");

endmodule

`default_nettype wire

// ===== sv/reliable_link_connection_fsm.sv =====
`default_nettype none

// channel | ports                                   | accepted when
// --------+-----------------------------------------+------------------------
// in      | in_valid, in_stall, in_kind .. in_ack_*  | in_valid && !in_stall
// out     | out_valid, out_stall, out_send_kind ..   | out_valid && !out_stall
// cfg     | cfg_wr_en, cfg_index, cfg_data           | cfg_wr_en
//
// A request passes an input register, then link logic that updates the state and
// writes a group of one to three result items into a two-group buffer. Results
// leave one per cycle while out_stall is low. An accepted request waits in the input
// register while the buffer is full; out_valid rises when its group is registered.
// Reset (rst_n low, synchronous) restores the register defaults and the link state.
// in_stall rises only while the input register holds a request and the buffer is full.

module reliable_link_connection_fsm #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [2:0]  in_pkt_type,
  input  wire logic        in_reliable_flag,
  input  wire logic [7:0]  in_header_seq,
  input  wire logic        in_header_seq_present,
  input  wire logic [7:0]  in_ack_seq,
  input  wire logic        in_ack_seq_present,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_send_kind,
  output logic [7:0]       out_send_seq,
  output logic [2:0]       out_link_state,
  output logic [1:0]       out_reason,
  output logic             out_eaten,
  output logic             out_queue_full,
  output logic             out_last,

  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  rlc_pkg::cfg_t     cfg_r;
  rlc_pkg::in_item_t item_r;
  logic              item_vld_r;
  logic              fifo_full, fire, load;
  rlc_pkg::grp_t     grp;
  rlc_pkg::res_t     res;

  assign in_stall = item_vld_r && fifo_full;
  assign load     = in_valid && !in_stall;
  assign fire     = item_vld_r && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.is_server    <= 1'b0;
      cfg_r.timeout_ms   <= rlc_pkg::TIMEOUT_MS_RST;
      cfg_r.keepalive_ms <= rlc_pkg::KEEPALIVE_MS_RST;
      cfg_r.resend_ms    <= rlc_pkg::RESEND_MS_RST;
      cfg_r.retry_ms     <= rlc_pkg::RETRY_MS_RST;
      cfg_r.retry_limit  <= rlc_pkg::RETRY_LIMIT_RST;
      cfg_r.sleep_ms     <= rlc_pkg::SLEEP_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rlc_pkg::CFG_IS_SERVER:    cfg_r.is_server    <= cfg_data[0];
        rlc_pkg::CFG_TIMEOUT_MS:   cfg_r.timeout_ms   <= cfg_data;
        rlc_pkg::CFG_KEEPALIVE_MS: cfg_r.keepalive_ms <= cfg_data;
        rlc_pkg::CFG_RESEND_MS:    cfg_r.resend_ms    <= cfg_data;
        rlc_pkg::CFG_RETRY_MS:     cfg_r.retry_ms     <= cfg_data;
        rlc_pkg::CFG_RETRY_LIMIT:  cfg_r.retry_limit  <= cfg_data[3:0];
        rlc_pkg::CFG_SLEEP_MS:     cfg_r.sleep_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (load) begin
      item_vld_r <= 1'b1;
    end else if (fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (load) begin
      item_r.kind               <= in_kind;
      item_r.now_ms             <= in_now_ms;
      item_r.pkt_type           <= in_pkt_type;
      item_r.reliable_flag      <= in_reliable_flag;
      item_r.header_seq         <= in_header_seq;
      item_r.header_seq_present <= in_header_seq_present;
      item_r.ack_seq            <= in_ack_seq;
      item_r.ack_seq_present    <= in_ack_seq_present;
    end
  end

  rlc_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .grp   (grp)
  );

  rlc_grp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .grp_in    (grp),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_send_kind  = res.send_kind;
  assign out_send_seq   = res.send_seq;
  assign out_link_state = res.link_state;
  assign out_reason     = res.reason;
  assign out_eaten      = res.eaten;
  assign out_queue_full = res.queue_full;
  assign out_last       = res.last;

endmodule

`default_nettype wire

// ===== test/link_event_checker.sv =====
`timescale 1ns / 100ps

module link_event_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rlc_pkg::in_item_t req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rlc_pkg::res_t     rsp,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                backlog
);

  logic        is_server;
  logic [31:0] timeout_ms, keepalive_ms, resend_ms, retry_ms, sleep_ms;
  logic [3:0]  retry_limit;

  logic [2:0]  link;
  logic [1:0]  why;
  logic [7:0]  tx_seq, rx_seq;
  logic [31:0] rx_time, tx_time, disc_time, head_time;
  logic        disc_sent, head_sent;
  logic [3:0]  retries;
  logic [4:0]  unacked;

  logic [2:0]    send_kinds[$];
  logic [7:0]    send_seqs[$];
  rlc_pkg::res_t due_results[$];
  int            fails = 0;

  function automatic logic [7:0] head_seq();
    return tx_seq - 8'(unacked);
  endfunction

  task automatic emit(input logic [2:0] k, input logic [7:0] s);
    send_kinds.push_back(k);
    send_seqs.push_back(s);
  endtask

  task automatic run_timers(input logic [31:0] now);
    case (link)
      rlc_pkg::ST_CONNECTED: begin
        if (32'(now - rx_time) > timeout_ms) begin
          link = rlc_pkg::ST_DISCONNECTED;
          why  = rlc_pkg::RS_TIMEOUT;
        end
        if (32'(now - tx_time) > keepalive_ms) begin
          emit(rlc_pkg::SK_KEEPALIVE, 8'd0);
          tx_time = now;
        end
        if (unacked != 0 && (!head_sent || 32'(now - head_time) > resend_ms)) begin
          emit(rlc_pkg::SK_RESEND, head_seq());
          tx_time   = now;
          head_time = now;
          head_sent = 1'b1;
        end
      end
      rlc_pkg::ST_DISCONNECTING: begin
        if (!disc_sent || 32'(now - disc_time) > retry_ms) begin
          if (retries < retry_limit) begin
            emit(rlc_pkg::SK_DISC, 8'd0);
            tx_time   = now;
            disc_time = now;
            disc_sent = 1'b1;
            retries   = retries + 4'd1;
          end else begin
            link = rlc_pkg::ST_DISCONNECTED;
            why  = rlc_pkg::RS_LOCAL;
          end
        end
      end
      rlc_pkg::ST_SLEEP: begin
        if (32'(now - disc_time) > sleep_ms) begin
          link = rlc_pkg::ST_DISCONNECTED;
          why  = rlc_pkg::RS_REMOTE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_packet(input rlc_pkg::in_item_t r, output logic eaten);
    logic in_order;
    eaten   = 1'b1;
    rx_time = r.now_ms;
    if (r.reliable_flag) begin
      if (!r.header_seq_present) return;
      in_order = (r.header_seq == rx_seq);
      if (in_order) rx_seq = rx_seq + 8'd1;
      emit(rlc_pkg::SK_REL_ACK, rx_seq);
      tx_time = r.now_ms;
      if (!in_order) return;
    end
    case (r.pkt_type)
      rlc_pkg::PT_DISC: begin
        emit(rlc_pkg::SK_DISC_ACK, 8'd0);
        tx_time   = r.now_ms;
        disc_time = r.now_ms;
        disc_sent = 1'b1;
        link      = rlc_pkg::ST_SLEEP;
        why       = rlc_pkg::RS_REMOTE;
      end
      rlc_pkg::PT_DISC_ACK: begin
        if (link == rlc_pkg::ST_DISCONNECTING) begin
          link      = rlc_pkg::ST_DISCONNECTED;
          why       = rlc_pkg::RS_LOCAL;
          disc_sent = 1'b0;
        end
      end
      rlc_pkg::PT_KEEPALIVE: ;
      rlc_pkg::PT_REL_ACK: begin
        if (r.ack_seq_present && unacked != 0 && r.ack_seq == head_seq() + 8'd1) begin
          unacked   = unacked - 5'd1;
          head_sent = 1'b0;
        end
      end
      default: eaten = 1'b0;
    endcase
  endtask

  task automatic advance_link(input rlc_pkg::in_item_t r);
    logic eaten, full;
    rlc_pkg::res_t item;
    eaten = 1'b0;
    full  = 1'b0;
    send_kinds.delete();
    send_seqs.delete();
    case (r.kind)
      rlc_pkg::EV_OPEN: begin
        disc_sent = 1'b0;
        disc_time = '0;
        retries   = '0;
        unacked   = '0;
        head_sent = 1'b0;
        head_time = '0;
        tx_seq    = '0;
        rx_seq    = '0;
        rx_time   = r.now_ms;
        tx_time   = r.now_ms;
        why       = rlc_pkg::RS_NONE;
        link      = is_server ? rlc_pkg::ST_CONNECTED : rlc_pkg::ST_CONNECTING;
      end
      rlc_pkg::EV_TICK: run_timers(r.now_ms);
      rlc_pkg::EV_PACKET: take_packet(r, eaten);
      rlc_pkg::EV_DISC_REQ: begin
        if (link != rlc_pkg::ST_DISCONNECTED && link != rlc_pkg::ST_DISCONNECTING &&
            link != rlc_pkg::ST_SLEEP) begin
          link      = rlc_pkg::ST_DISCONNECTING;
          why       = rlc_pkg::RS_LOCAL;
          disc_sent = 1'b0;
          retries   = '0;
        end
      end
      rlc_pkg::EV_NEW_REL: begin
        if (unacked >= QUEUE_DEPTH) begin
          full = 1'b1;
        end else begin
          emit(rlc_pkg::SK_NEW_REL, tx_seq);
          if (unacked == 0) head_sent = 1'b0;
          unacked = unacked + 5'd1;
          tx_seq  = tx_seq + 8'd1;
        end
      end
      rlc_pkg::EV_HS_DONE: begin
        if (link == rlc_pkg::ST_CONNECTING) link = rlc_pkg::ST_CONNECTED;
      end
      default: ;
    endcase
    emit(rlc_pkg::SK_STATUS, 8'd0);
    for (int k = 0; k < send_kinds.size(); k++) begin
      item.send_kind  = send_kinds[k];
      item.send_seq   = send_seqs[k];
      item.link_state = link;
      item.reason     = why;
      item.eaten      = eaten;
      item.queue_full = full;
      item.last       = (k == send_kinds.size() - 1);
      due_results.push_back(item);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result(input rlc_pkg::res_t got);
    rlc_pkg::res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: expected no result, got kind %0d seq %0d", $time,
               got.send_kind, got.send_seq);
      fails++;
      return;
    end
    want = due_results.pop_front();
    check_field("send_kind", 8'(want.send_kind), 8'(got.send_kind));
    check_field("send_seq", want.send_seq, got.send_seq);
    check_field("link_state", 8'(want.link_state), 8'(got.link_state));
    check_field("reason", 8'(want.reason), 8'(got.reason));
    check_field("eaten", 8'(want.eaten), 8'(got.eaten));
    check_field("queue_full", 8'(want.queue_full), 8'(got.queue_full));
    check_field("last", 8'(want.last), 8'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      is_server    = 1'b0;
      timeout_ms   = rlc_pkg::TIMEOUT_MS_RST;
      keepalive_ms = rlc_pkg::KEEPALIVE_MS_RST;
      resend_ms    = rlc_pkg::RESEND_MS_RST;
      retry_ms     = rlc_pkg::RETRY_MS_RST;
      retry_limit  = rlc_pkg::RETRY_LIMIT_RST;
      sleep_ms     = rlc_pkg::SLEEP_MS_RST;
      link      = rlc_pkg::ST_CONNECTING;
      why       = rlc_pkg::RS_NONE;
      tx_seq    = '0;
      rx_seq    = '0;
      rx_time   = '0;
      tx_time   = '0;
      disc_time = '0;
      disc_sent = 1'b0;
      retries   = '0;
      unacked   = '0;
      head_time = '0;
      head_sent = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rlc_pkg::CFG_IS_SERVER:    is_server    = cfg_data[0];
          rlc_pkg::CFG_TIMEOUT_MS:   timeout_ms   = cfg_data;
          rlc_pkg::CFG_KEEPALIVE_MS: keepalive_ms = cfg_data;
          rlc_pkg::CFG_RESEND_MS:    resend_ms    = cfg_data;
          rlc_pkg::CFG_RETRY_MS:     retry_ms     = cfg_data;
          rlc_pkg::CFG_RETRY_LIMIT:  retry_limit  = cfg_data[3:0];
          rlc_pkg::CFG_SLEEP_MS:     sleep_ms     = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_result(rsp);
      if (in_valid && !in_stall) advance_link(req);
    end
    errors  <= fails;
    backlog <= due_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 16;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rlc_pkg::in_item_t req;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_send_kind;
  logic [7:0]        out_send_seq;
  logic [2:0]        out_link_state;
  logic [1:0]        out_reason;
  logic              out_eaten;
  logic              out_queue_full;
  logic              out_last;
  rlc_pkg::res_t     rsp;
  logic              cfg_wr_en;
  logic [2:0]        cfg_index;
  logic [31:0]       cfg_data;
  int                errors;
  int                backlog;

  bit          quiet;
  logic [31:0] clock_ms;
  int          step_max;
  logic [7:0]  m_tx, m_rx;
  int          m_pend;

  reliable_link_connection_fsm #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (req.kind),
    .in_now_ms             (req.now_ms),
    .in_pkt_type           (req.pkt_type),
    .in_reliable_flag      (req.reliable_flag),
    .in_header_seq         (req.header_seq),
    .in_header_seq_present (req.header_seq_present),
    .in_ack_seq            (req.ack_seq),
    .in_ack_seq_present    (req.ack_seq_present),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_send_kind         (out_send_kind),
    .out_send_seq          (out_send_seq),
    .out_link_state        (out_link_state),
    .out_reason            (out_reason),
    .out_eaten             (out_eaten),
    .out_queue_full        (out_queue_full),
    .out_last              (out_last),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  assign rsp = {out_send_kind, out_send_seq, out_link_state, out_reason,
                out_eaten, out_queue_full, out_last};

  link_event_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req       (req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .backlog   (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic rlc_pkg::in_item_t ev(input logic [2:0] kind, input logic [31:0] now);
    rlc_pkg::in_item_t r;
    r = '0;
    r.kind = kind;
    r.now_ms = now;
    return r;
  endfunction

  function automatic rlc_pkg::in_item_t pkt(input logic [31:0] now, input logic [2:0] ptype,
                                            input logic rel, input logic [7:0] hseq,
                                            input logic hpres, input logic [7:0] aseq,
                                            input logic apres);
    rlc_pkg::in_item_t r;
    r = ev(rlc_pkg::EV_PACKET, now);
    r.pkt_type           = ptype;
    r.reliable_flag      = rel;
    r.header_seq         = hseq;
    r.header_seq_present = hpres;
    r.ack_seq            = aseq;
    r.ack_seq_present    = apres;
    return r;
  endfunction

  // follow sequence numbers loosely so that most acks and headers line up
  function automatic void track(input rlc_pkg::in_item_t r);
    logic body;
    case (r.kind)
      rlc_pkg::EV_OPEN: begin
        m_tx = '0;
        m_rx = '0;
        m_pend = 0;
      end
      rlc_pkg::EV_NEW_REL: begin
        if (m_pend < DEPTH) begin
          m_pend++;
          m_tx = m_tx + 8'd1;
        end
      end
      rlc_pkg::EV_PACKET: begin
        body = 1'b1;
        if (r.reliable_flag) begin
          if (r.header_seq_present && r.header_seq == m_rx) m_rx = m_rx + 8'd1;
          else body = 1'b0;
        end
        if (body && r.pkt_type == rlc_pkg::PT_REL_ACK && r.ack_seq_present && m_pend > 0 &&
            r.ack_seq == 8'(m_tx - 8'(m_pend) + 8'd1))
          m_pend--;
      end
      default: ;
    endcase
  endfunction

  function automatic rlc_pkg::in_item_t next_req();
    rlc_pkg::in_item_t r;
    int                pick;
    logic [63:0]       bits;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    r = ev(rlc_pkg::EV_TICK, clock_ms);
    if (pick < 3) begin
      r.kind = rlc_pkg::EV_OPEN;
    end else if (pick < 8) begin
      r.kind = rlc_pkg::EV_HS_DONE;
    end else if (pick < 30) begin
      r.kind = rlc_pkg::EV_TICK;
    end else if (pick < 52) begin
      r.kind = rlc_pkg::EV_NEW_REL;
    end else if (pick < 92) begin
      r.kind = rlc_pkg::EV_PACKET;
      r.reliable_flag      = 1'($urandom_range(0, 1));
      r.header_seq_present = ($urandom_range(0, 19) != 0);
      r.header_seq         = ($urandom_range(0, 6) != 0) ? m_rx : 8'($urandom());
      r.ack_seq_present    = ($urandom_range(0, 9) != 0);
      r.ack_seq = ($urandom_range(0, 6) != 0) ? 8'(m_tx - 8'(m_pend) + 8'd1)
                                              : 8'($urandom());
      if (pick < 80) r.pkt_type = rlc_pkg::PT_REL_ACK;
      else if (pick < 84) r.pkt_type = rlc_pkg::PT_KEEPALIVE;
      else if (pick < 86) r.pkt_type = rlc_pkg::PT_DISC_ACK;
      else if (pick < 87) r.pkt_type = rlc_pkg::PT_DISC;
      else r.pkt_type = 3'($urandom_range(4, 7));
    end else if (pick < 96) begin
      r.kind = rlc_pkg::EV_DISC_REQ;
    end else begin
      bits = {$urandom(), $urandom()};
      r = bits[56:0];
    end
    return r;
  endfunction

  task automatic send_req(input rlc_pkg::in_item_t r);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    in_valid <= 1'b1;
    track(r);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(input logic srv, input logic [31:0] tmo, input logic [31:0] ka,
                          input logic [31:0] rs, input logic [31:0] rt,
                          input logic [3:0] mr, input logic [31:0] sl);
    drain();
    write_reg(rlc_pkg::CFG_IS_SERVER, {31'd0, srv});
    write_reg(rlc_pkg::CFG_TIMEOUT_MS, tmo);
    write_reg(rlc_pkg::CFG_KEEPALIVE_MS, ka);
    write_reg(rlc_pkg::CFG_RESEND_MS, rs);
    write_reg(rlc_pkg::CFG_RETRY_MS, rt);
    write_reg(rlc_pkg::CFG_RETRY_LIMIT, {28'd0, mr});
    write_reg(rlc_pkg::CFG_SLEEP_MS, sl);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) quiet = ~quiet;
      if ($urandom_range(0, 79) == 0) drain();
      send_req(next_req());
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      int hold;
      @(negedge clk);
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    req       = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    clock_ms  = '0;
    step_max  = 1000;
    m_tx      = '0;
    m_rx      = '0;
    m_pend    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_req(ev(rlc_pkg::EV_OPEN, 32'd100));
    send_req(ev(rlc_pkg::EV_HS_DONE, 32'd110));
    send_req(ev(rlc_pkg::EV_HS_DONE, 32'd115));
    send_req(ev(rlc_pkg::EV_NEW_REL, 32'd120));
    send_req(ev(rlc_pkg::EV_NEW_REL, 32'd125));
    send_req(ev(rlc_pkg::EV_TICK, 32'd200));
    send_req(pkt(32'd210, rlc_pkg::PT_REL_ACK, 1'b0, 8'd0, 1'b0, 8'd1, 1'b1));
    send_req(pkt(32'd220, rlc_pkg::PT_REL_ACK, 1'b0, 8'd0, 1'b0, 8'hff, 1'b1));
    send_req(pkt(32'd230, rlc_pkg::PT_REL_ACK, 1'b0, 8'd0, 1'b0, 8'd2, 1'b0));
    send_req(pkt(32'd240, rlc_pkg::PT_OTHER, 1'b1, 8'd0, 1'b0, 8'd0, 1'b0));
    send_req(pkt(32'd245, rlc_pkg::PT_KEEPALIVE, 1'b1, 8'hff, 1'b1, 8'd0, 1'b0));
    send_req(pkt(32'd250, rlc_pkg::PT_OTHER, 1'b1, 8'd0, 1'b1, 8'd0, 1'b0));
    send_req(pkt(32'd260, 3'd7, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    send_req(pkt(32'd270, rlc_pkg::PT_KEEPALIVE, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    send_req(pkt(32'd280, rlc_pkg::PT_DISC_ACK, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    // timeout, keepalive and resend out of one tick
    send_req(ev(rlc_pkg::EV_TICK, 32'hffff_ffff));
    send_req(ev(rlc_pkg::EV_DISC_REQ, 32'hffff_ffff));
    send_req(ev(rlc_pkg::EV_OPEN, 32'hffff_ff00));
    send_req(ev(rlc_pkg::EV_DISC_REQ, 32'hffff_ff05));
    send_req(ev(rlc_pkg::EV_DISC_REQ, 32'hffff_ff08));
    send_req(ev(rlc_pkg::EV_TICK, 32'hffff_ff10));
    send_req(pkt(32'hffff_ff20, rlc_pkg::PT_DISC_ACK, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    send_req(ev(rlc_pkg::EV_OPEN, 32'd5));
    send_req(pkt(32'd10, rlc_pkg::PT_DISC, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    send_req(ev(rlc_pkg::EV_TICK, 32'd5020));
    send_req(ev(3'd6, 32'd5030));
    send_req(ev(3'd7, 32'd5040));
    clock_ms = 32'd6000;

    set_regs(1'b1, 32'd3000, 32'd500, 32'd700, 32'd300, 4'd3, 32'd2000);
    send_req(ev(rlc_pkg::EV_OPEN, clock_ms));
    repeat (20) send_req(ev(rlc_pkg::EV_NEW_REL, clock_ms));
    run_random(190);

    set_regs(1'b0, 32'd1, 32'd1, 32'd1, 32'd1, 4'd0, 32'd1);
    step_max = 3;
    run_random(60);

    set_regs(1'b1, '1, '1, '1, '1, 4'd15, '1);
    step_max = 1000;
    run_random(50);

    set_regs(1'($urandom_range(0, 1)), $urandom_range(1, 2500), $urandom_range(1, 2500),
             $urandom_range(1, 2500), $urandom_range(1, 2500), 4'($urandom_range(0, 15)),
             $urandom_range(1, 2500));
    step_max = 2000;
    run_random(70);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
